### rtl/core/assert_macros.svh
// Assertion macros shared by the packed alpha bitmap unpacker RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define PABU_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block's usual clock_i / rst_ni pair.
`define PABU_ASSERT(label, prop, msg) \
  `PABU_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

### rtl/core/pabu_pkg.sv
// Package of the packed alpha bitmap unpacker: types, register codes and
// pixel expansion helpers. No dependencies.
package pabu_pkg;

  localparam int unsigned MaxGlyphSideDef = 256;
  localparam int unsigned CfgSideW        = 9;
  localparam int unsigned CfgAddrW        = 4;
  localparam int unsigned CfgDataW        = 32;

  typedef enum logic [1:0] {
    BPP_1 = 2'd0,
    BPP_2 = 2'd1,
    BPP_4 = 2'd2,
    BPP_8 = 2'd3
  } bpp_mode_e;

  typedef enum logic [1:0] {
    REG_BPP_MODE    = 2'd0,
    REG_ROW_ALIGNED = 2'd1,
    REG_GLYPH_WIDTH = 2'd2,
    REG_GLYPH_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    bpp_mode_e             bpp_mode;
    logic                  row_byte_aligned;
    logic [CfgSideW-1:0]   glyph_width;
    logic [CfgSideW-1:0]   glyph_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] pixel_column;
    logic [7:0] pixel_row;
    logic       row_end;
    logic       glyph_end;
    logic       last_of_byte;
  } pixel_t;

  // Number of bits one pixel occupies.
  function automatic logic [3:0] bpp_bits(bpp_mode_e mode);
    logic [3:0] bits;
    unique case (mode)
      BPP_1:   bits = 4'd1;
      BPP_2:   bits = 4'd2;
      BPP_4:   bits = 4'd4;
      default: bits = 4'd8;
    endcase
    return bits;
  endfunction

  // Expands the pixel in the top bits of the byte to 0..255. Replicating the
  // value is the same as multiplying by 255, 85 or 17.
  function automatic logic [7:0] expand_alpha(logic [7:0] data, bpp_mode_e mode);
    logic [7:0] a;
    unique case (mode)
      BPP_1:   a = {8{data[7]}};
      BPP_2:   a = {4{data[7:6]}};
      BPP_4:   a = {2{data[7:4]}};
      default: a = data;
    endcase
    return a;
  endfunction

endpackage

### rtl/core/pabu_if.sv
// Valid/ready channel interfaces for the packed alpha bitmap unpacker.
// Depends on nothing; the input and result transactions each have one.
interface pabu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       glyph_start;

  modport source (output valid, output packed_byte, output glyph_start, input ready);
  modport sink   (input valid, input packed_byte, input glyph_start, output ready);
endinterface

interface pabu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] alpha;
  logic [7:0] pixel_column;
  logic [7:0] pixel_row;
  logic       row_end;
  logic       glyph_end;
  logic       last_of_byte;

  modport source (output valid, output alpha, output pixel_column, output pixel_row,
                  output row_end, output glyph_end, output last_of_byte, input ready);
  modport sink   (input valid, input alpha, input pixel_column, input pixel_row,
                  input row_end, input glyph_end, input last_of_byte, output ready);
endinterface

### rtl/core/packed_alpha_bitmap_unpacker.sv
// Top level of the packed alpha bitmap unpacker.
// Depends on pabu_pkg, pabu_if, pabu_cfg, pabu_core and pabu_outreg.
//
//   Channel  Direction  Transaction
//   in_ch    sink       one packed bitmap byte plus glyph start flag
//   out_ch   source     one expanded alpha pixel with position and end flags
//   APB      slave      write or read of one configuration register
//
// One pixel leaves per cycle while the result channel is ready. A byte holds 8,
// 4, 2 or 1 pixels at 1, 2, 4 or 8 bits per pixel, fewer when the glyph, or
// with row alignment a row, ends in it; a byte outside any glyph is dropped.
// The byte register and its shifter set this rate, emitting one pixel per cycle
// while the result register has room. The next byte is taken in the cycle that
// the current byte's last pixel goes into the result register. A stalled result
// channel holds the result and byte registers; reset leaves no glyph active.
module packed_alpha_bitmap_unpacker import pabu_pkg::*; #(
  parameter int unsigned MAX_GLYPH_SIDE = MaxGlyphSideDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  pabu_in_if.sink             in_ch,
  pabu_out_if.source          out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  // Configuration, written by the user only while the block is idle; the block does not enforce it.
  cfg_t   cfg;
  // Pixel handed from the unpacker to the result register.
  pixel_t pix;
  logic   emit;
  logic   space;

  pabu_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The unpacker holds the current byte, tracks column, row and the glyph state,
  // and produces one pixel for a glyph byte whenever the result register has room.
  pabu_core #(
    .MAX_GLYPH_SIDE (MAX_GLYPH_SIDE)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .cfg_i   (cfg),
    .space_i (space),
    .emit_o  (emit),
    .pix_o   (pix)
  );

  // The result register holds a pixel for the result channel; the unpacker stalls while it waits.
  pabu_outreg u_outreg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .emit_i  (emit),
    .pix_i   (pix),
    .space_o (space),
    .out_ch  (out_ch)
  );

endmodule

### rtl/core/pabu_cfg.sv
// APB configuration registers of the packed alpha bitmap unpacker.
// Depends on pabu_pkg.
module pabu_cfg import pabu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e sel;
  logic     wr_en;

  assign sel    = cfg_reg_e'(paddr[CfgAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        REG_BPP_MODE:     cfg_d.bpp_mode         = bpp_mode_e'(pwdata[1:0]);
        REG_ROW_ALIGNED:  cfg_d.row_byte_aligned = pwdata[0];
        REG_GLYPH_WIDTH:  cfg_d.glyph_width      = pwdata[CfgSideW-1:0];
        default:          cfg_d.glyph_height     = pwdata[CfgSideW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_BPP_MODE:    prdata = CfgDataW'(cfg_q.bpp_mode);
      REG_ROW_ALIGNED: prdata = CfgDataW'(cfg_q.row_byte_aligned);
      REG_GLYPH_WIDTH: prdata = CfgDataW'(cfg_q.glyph_width);
      default:         prdata = CfgDataW'(cfg_q.glyph_height);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bpp_mode         <= BPP_8;
      cfg_q.row_byte_aligned <= 1'b0;
      cfg_q.glyph_width      <= CfgSideW'(1);
      cfg_q.glyph_height     <= CfgSideW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/core/pabu_core.sv
// Byte register, position counters and per-pixel unpacking logic.
// Depends on pabu_pkg, pabu_if and assert_macros.svh.
`include "assert_macros.svh"
module pabu_core import pabu_pkg::*; #(
  parameter int unsigned MAX_GLYPH_SIDE = MaxGlyphSideDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  pabu_in_if.sink in_ch,
  input  cfg_t   cfg_i,
  input  logic   space_i,
  output logic   emit_o,
  output pixel_t pix_o
);

  localparam int unsigned CW = $clog2(MAX_GLYPH_SIDE);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned LW = (SW > CfgSideW) ? SW : CfgSideW;
  localparam int unsigned PW = (CW > 8) ? CW : 8;

  logic          proc_valid_q, proc_valid_d;
  logic [7:0]    byte_q, byte_d;
  logic          start_q, start_d;
  logic [3:0]    off_q, off_d;
  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic          complete_q, complete_d;

  logic [CW-1:0] eff_col, eff_row;
  logic          eff_complete;
  logic [3:0]    bpp, next_off;
  logic [LW-1:0] w_ext, h_ext;
  logic [SW-1:0] width_c, height_c;
  logic          row_done, glyph_done, last_pix;
  logic          advance, proc_done, accept;
  logic [PW-1:0] col_ext, row_ext;

  // A glyph start takes effect when its byte reaches the first pixel.
  assign eff_col      = start_q ? '0 : col_q;
  assign eff_row      = start_q ? '0 : row_q;
  assign eff_complete = complete_q && !start_q;

  assign bpp      = bpp_bits(cfg_i.bpp_mode);
  assign next_off = off_q + bpp;

  always_comb begin
    w_ext = LW'(cfg_i.glyph_width);
    h_ext = LW'(cfg_i.glyph_height);
    if (w_ext == '0) begin
      w_ext = LW'(1);
    end else if (w_ext > LW'(MAX_GLYPH_SIDE)) begin
      w_ext = LW'(MAX_GLYPH_SIDE);
    end
    if (h_ext == '0) begin
      h_ext = LW'(1);
    end else if (h_ext > LW'(MAX_GLYPH_SIDE)) begin
      h_ext = LW'(MAX_GLYPH_SIDE);
    end
  end
  assign width_c  = w_ext[SW-1:0];
  assign height_c = h_ext[SW-1:0];

  assign row_done   = (SW'(eff_col) + SW'(1)) >= width_c;
  assign glyph_done = row_done && ((SW'(eff_row) + SW'(1)) >= height_c);
  assign last_pix   = next_off[3] || glyph_done || (row_done && cfg_i.row_byte_aligned);

  assign advance   = proc_valid_q && space_i;
  assign emit_o    = advance && !eff_complete;
  assign proc_done = advance && (eff_complete || last_pix);

  assign in_ch.ready = !proc_valid_q || proc_done;
  assign accept      = in_ch.valid && in_ch.ready;

  assign col_ext            = PW'(eff_col);
  assign row_ext            = PW'(eff_row);
  assign pix_o.alpha        = expand_alpha(byte_q, cfg_i.bpp_mode);
  assign pix_o.pixel_column = col_ext[7:0];
  assign pix_o.pixel_row    = row_ext[7:0];
  assign pix_o.row_end      = row_done;
  assign pix_o.glyph_end    = glyph_done;
  assign pix_o.last_of_byte = last_pix;

  always_comb begin
    proc_valid_d = proc_valid_q;
    byte_d       = byte_q;
    start_d      = start_q;
    off_d        = off_q;
    if (accept) begin
      proc_valid_d = 1'b1;
      byte_d       = in_ch.packed_byte;
      start_d      = in_ch.glyph_start;
      off_d        = '0;
    end else if (proc_done) begin
      proc_valid_d = 1'b0;
    end else if (emit_o) begin
      byte_d  = byte_q << bpp;
      off_d   = next_off;
      start_d = 1'b0;
    end
  end

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    complete_d = complete_q;
    if (emit_o) begin
      complete_d = glyph_done;
      if (row_done) begin
        col_d = '0;
        row_d = glyph_done ? eff_row : eff_row + CW'(1);
      end else begin
        col_d = eff_col + CW'(1);
        row_d = eff_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_valid_q <= 1'b0;
      byte_q       <= '0;
      start_q      <= 1'b0;
      off_q        <= '0;
      col_q        <= '0;
      row_q        <= '0;
      complete_q   <= 1'b1;
    end else begin
      proc_valid_q <= proc_valid_d;
      byte_q       <= byte_d;
      start_q      <= start_d;
      off_q        <= off_d;
      col_q        <= col_d;
      row_q        <= row_d;
      complete_q   <= complete_d;
    end
  end

  `PABU_ASSERT(a_glyph_end_completes, emit_o && glyph_done |=> complete_q, "glyph end not recorded")
  `PABU_ASSERT(a_complete_col_zero, complete_q |-> col_q == '0, "column left non-zero after glyph")
  `PABU_ASSERT(a_busy_blocks_input, proc_valid_q && !proc_done |-> !in_ch.ready, "input taken while byte still unpacking")
  `PABU_ASSERT(a_offset_in_byte, proc_valid_q |-> !off_q[3], "bit offset ran past the byte")

endmodule

### rtl/core/pabu_outreg.sv
// Result register that decouples pixel generation from the result channel.
// Depends on pabu_pkg and pabu_if.
module pabu_outreg import pabu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    emit_i,
  input  pixel_t  pix_i,
  output logic    space_o,
  pabu_out_if.source out_ch
);

  logic   valid_q, valid_d;
  pixel_t pix_q, pix_d;

  assign space_o = !valid_q || out_ch.ready;

  always_comb begin
    valid_d = valid_q;
    pix_d   = pix_q;
    if (emit_i) begin
      valid_d = 1'b1;
      pix_d   = pix_i;
    end else if (out_ch.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  assign out_ch.valid        = valid_q;
  assign out_ch.alpha        = pix_q.alpha;
  assign out_ch.pixel_column = pix_q.pixel_column;
  assign out_ch.pixel_row    = pix_q.pixel_row;
  assign out_ch.row_end      = pix_q.row_end;
  assign out_ch.glyph_end    = pix_q.glyph_end;
  assign out_ch.last_of_byte = pix_q.last_of_byte;

endmodule
